// ----- hdl/bcgb_pkg.sv -----
// Package for the buffer capacity growth budget block.
// Holds field widths, reset constants, payload structs, codes and control structs.
// Used by every module in hdl; depends on nothing.
`default_nettype none

package bcgb_pkg;

    // Fixed field widths of the ports
    localparam int FIELD_W = 40;
    localparam int CNT_FIELD_W = 32;

    // Defaults for the top-level parameters
    localparam int DEF_SIZE_WIDTH = 40;
    localparam int DEF_COUNT_WIDTH = 32;

    // Growth step floor and configuration reset values
    localparam logic [FIELD_W-1:0] GROW_FLOOR = FIELD_W'(4096);
    localparam logic [FIELD_W-1:0] BUDGET_RESET = FIELD_W'(268435456);
    localparam logic [FIELD_W-1:0] MINIMUM_RESET = FIELD_W'(4096);

    // Configuration register indexes
    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_MINIMUM = 1'b1;

    // Request types
    localparam logic REQ_CAPACITY = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FIT     = 2'd0,
        ST_GROWN   = 2'd1,
        ST_REJECT  = 2'd2,
        ST_RELEASE = 2'd3
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] required_bytes;
    } t_request;

    typedef struct packed {
        t_status                status;
        logic [FIELD_W-1:0]     capacity_bytes;
        logic [FIELD_W-1:0]     peak_bytes;
        logic [CNT_FIELD_W-1:0] rejection_count;
        logic [CNT_FIELD_W-1:0] reallocation_count;
    } t_result;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_GROW
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    init_next;
        logic    step;
        logic    commit;
        t_status outcome;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_release;
        logic fits;
        logic over_budget;
        logic reached;
        logic carry;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/buffer_capacity_growth_budget.sv -----
// Buffer capacity growth budget, top level: controller plus datapath.
// Release, fitting and over-budget requests commit in S_EVAL; o_valid is registered
// from the commit. Growing requests pass through S_GROW, where the single adder does
// one growth addition per step until the size is reached or the sum carries. A new
// request is accepted in the cycle the result is strobed. Sync reset clears capacity,
// peak, counters, loads budget 268435456 and minimum 4096; the receiver cannot stall.
`default_nettype none

module buffer_capacity_growth_budget #(
    parameter int SIZE_WIDTH = bcgb_pkg::DEF_SIZE_WIDTH,
    parameter int COUNT_WIDTH = bcgb_pkg::DEF_COUNT_WIDTH
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    output logic                        o_busy,
    input  wire bcgb_pkg::t_request     i_request,
    output logic                        o_valid,
    output bcgb_pkg::t_result           o_result,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire                         i_cfg_index,
    input  wire [bcgb_pkg::FIELD_W-1:0] i_cfg_data
);
    import bcgb_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration transfer is always taken
    assign o_cfg_ready = 1'b1;

    bcgb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    bcgb_dp #(
        .SIZE_WIDTH  (SIZE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ----- hdl/bcgb_dp.sv -----
// Datapath of the buffer capacity growth budget block.
// Holds configuration, capacity state, counters, growth adder and result register.
// Depends on bcgb_pkg; driven by bcgb_ctrl commands.
`default_nettype none

module bcgb_dp #(
    parameter int SIZE_WIDTH = bcgb_pkg::DEF_SIZE_WIDTH,
    parameter int COUNT_WIDTH = bcgb_pkg::DEF_COUNT_WIDTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire bcgb_pkg::t_request            i_request,
    input  wire                                i_cfg_we,
    input  wire                                i_cfg_index,
    input  wire [bcgb_pkg::FIELD_W-1:0]        i_cfg_data,
    input  wire bcgb_pkg::t_dp_cmd             i_cmd,
    output bcgb_pkg::t_dp_stat                 o_stat,
    output logic                               o_valid,
    output bcgb_pkg::t_result                  o_result
);
    import bcgb_pkg::*;

    localparam logic [SIZE_WIDTH-1:0] SZ_ONE = SIZE_WIDTH'(1);
    localparam logic [SIZE_WIDTH-1:0] SZ_FLOOR = SIZE_WIDTH'(GROW_FLOOR);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [FIELD_W-1:0]     r_budget;
    logic [FIELD_W-1:0]     r_minimum;
    logic [SIZE_WIDTH-1:0]  r_cur;
    logic [SIZE_WIDTH-1:0]  r_peak;
    logic [COUNT_WIDTH-1:0] r_rej;
    logic [COUNT_WIDTH-1:0] r_grow;
    logic [SIZE_WIDTH-1:0]  r_req;
    logic                   r_release;
    logic [SIZE_WIDTH-1:0]  r_next;
    logic                   r_valid;
    t_result                r_result;

    logic [SIZE_WIDTH-1:0]  eff_budget;
    logic [SIZE_WIDTH-1:0]  min_raw;
    logic [SIZE_WIDTH-1:0]  eff_min;
    logic [SIZE_WIDTH-1:0]  half;
    logic [SIZE_WIDTH-1:0]  growth;
    logic [SIZE_WIDTH:0]    sum;
    logic [SIZE_WIDTH-1:0]  capped;
    logic [SIZE_WIDTH-1:0]  n_cur;
    logic [SIZE_WIDTH-1:0]  n_peak;
    logic [COUNT_WIDTH-1:0] n_rej;
    logic [COUNT_WIDTH-1:0] n_grow;
    logic [SIZE_WIDTH-1:0]  out_cap;

    // Clamp budget and minimum
    always_comb begin
        eff_budget = SIZE_WIDTH'(r_budget);
        if (eff_budget == '0) begin
            eff_budget = SZ_ONE;
        end
        min_raw = SIZE_WIDTH'(r_minimum);
        eff_min = (min_raw == '0) ? SZ_ONE : min_raw;
        if (eff_min > eff_budget) begin
            eff_min = eff_budget;
        end
    end

    // One growth step: add max(half, floor), watch the carry
    always_comb begin
        half = r_next >> 1;
        growth = (half < SZ_FLOOR) ? SZ_FLOOR : half;
        sum = {1'b0, r_next} + {1'b0, growth};
        capped = (r_next > eff_budget) ? eff_budget : r_next;
    end

    // Status for the controller
    always_comb begin
        o_stat.is_release = r_release;
        o_stat.fits = (r_req <= r_cur);
        o_stat.over_budget = (r_req > eff_budget);
        o_stat.reached = (r_next >= r_req);
        o_stat.carry = sum[SIZE_WIDTH];
    end

    // Next state values for the committed outcome
    always_comb begin
        n_cur = r_cur;
        n_peak = r_peak;
        n_rej = r_rej;
        n_grow = r_grow;
        out_cap = r_cur;
        unique case (i_cmd.outcome)
            ST_FIT: begin
                out_cap = r_cur;
            end
            ST_REJECT: begin
                if (r_rej != CNT_MAX) begin
                    n_rej = r_rej + COUNT_WIDTH'(1);
                end
            end
            ST_GROWN: begin
                n_cur = capped;
                out_cap = capped;
                if (capped > r_peak) begin
                    n_peak = capped;
                end
                if (r_grow != CNT_MAX) begin
                    n_grow = r_grow + COUNT_WIDTH'(1);
                end
            end
            ST_RELEASE: begin
                n_cur = '0;
                out_cap = '0;
            end
            default: begin
                out_cap = r_cur;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
            r_minimum <= MINIMUM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BUDGET) begin
                r_budget <= i_cfg_data;
            end else begin
                r_minimum <= i_cfg_data;
            end
        end
    end

    // Capacity state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_peak <= '0;
            r_rej <= '0;
            r_grow <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_cur <= n_cur;
                r_peak <= n_peak;
                r_rej <= n_rej;
                r_grow <= n_grow;
            end
        end
    end

    // Request capture, growth register and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= SIZE_WIDTH'(i_request.required_bytes);
            r_release <= (i_request.req_type == REQ_RELEASE);
        end
        if (i_cmd.init_next) begin
            r_next <= (eff_min > r_cur) ? eff_min : r_cur;
        end else if (i_cmd.step) begin
            r_next <= sum[SIZE_WIDTH-1:0];
        end
        if (i_cmd.commit) begin
            r_result.status <= i_cmd.outcome;
            r_result.capacity_bytes <= FIELD_W'(out_cap);
            r_result.peak_bytes <= FIELD_W'(n_peak);
            r_result.rejection_count <= CNT_FIELD_W'(n_rej);
            r_result.reallocation_count <= CNT_FIELD_W'(n_grow);
        end
    end

    assign o_valid = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hdl/bcgb_ctrl.sv -----
// Controller of the buffer capacity growth budget block.
// Sequences capture, evaluation and the growth loop; issues datapath commands.
// Depends on bcgb_pkg.
`default_nettype none

module bcgb_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire bcgb_pkg::t_dp_stat i_stat,
    output logic                  o_busy,
    output bcgb_pkg::t_dp_cmd     o_cmd
);
    import bcgb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.outcome = ST_FIT;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // release first, then fit, then budget check, else grow
                priority if (i_stat.is_release) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.outcome = ST_RELEASE;
                    n_state = S_IDLE;
                end else if (i_stat.fits) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.outcome = ST_FIT;
                    n_state = S_IDLE;
                end else if (i_stat.over_budget) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.outcome = ST_REJECT;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.init_next = 1'b1;
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                // stop once the size is reached; overflow rejects
                priority if (i_stat.reached) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.outcome = ST_GROWN;
                    n_state = S_IDLE;
                end else if (i_stat.carry) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.outcome = ST_REJECT;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
